@@ rtl/gtpc_pkg.sv @@
// ----------------------------------------------------------------------------
// gtpc_pkg: shared constants and helpers for the street-tile connectivity block
// Tile codes, opening helpers and default grid limits.
// ----------------------------------------------------------------------------
package gtpc_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int TILE_W = 3;
  localparam int DIM_W  = 7;

  localparam logic [TILE_W-1:0] TILE_LR = 3'd1;
  localparam logic [TILE_W-1:0] TILE_UD = 3'd2;
  localparam logic [TILE_W-1:0] TILE_LD = 3'd3;
  localparam logic [TILE_W-1:0] TILE_RD = 3'd4;
  localparam logic [TILE_W-1:0] TILE_LU = 3'd5;
  localparam logic [TILE_W-1:0] TILE_UR = 3'd6;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  function automatic logic opens_left(input logic [TILE_W-1:0] t);
    return (t == TILE_LR) || (t == TILE_LD) || (t == TILE_LU);
  endfunction

  function automatic logic opens_right(input logic [TILE_W-1:0] t);
    return (t == TILE_LR) || (t == TILE_RD) || (t == TILE_UR);
  endfunction

  function automatic logic opens_up(input logic [TILE_W-1:0] t);
    return (t == TILE_UD) || (t == TILE_LU) || (t == TILE_UR);
  endfunction

  function automatic logic opens_down(input logic [TILE_W-1:0] t);
    return (t == TILE_UD) || (t == TILE_LD) || (t == TILE_RD);
  endfunction

endpackage

@@ rtl/gtpc_ram.sv @@
// ----------------------------------------------------------------------------
// gtpc_ram: generic simple dual-port RAM (one write port, one read port)
// One write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module gtpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/grid_tile_path_connectivity.sv @@
// A cell with no joins passes through the init state and the left, upper and final
// setup phases before the block returns to idle, where a new tile beat is taken.
// Each join adds two finds, each a walk to the root (a read and a check state per node)
// followed by the compression pass, then the size reads and a link step for the roots.
// The last cell adds two finds before the result beat, which waits for out_ready.
// Reset: synchronous; position clears to the top-left cell, grid is 1 by 1.
// RAM contents are not cleared; every entry is written before it is read.
// ----------------------------------------------------------------------------
// grid_tile_path_connectivity: union-find connectivity over a street-tile grid
// A sequencer drives one RAM read port per store through find, compress and
// link steps for each arriving cell.
// ----------------------------------------------------------------------------
module grid_tile_path_connectivity
  import gtpc_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TILE_W-1:0] tile_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              path_exists,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [DIM_W-1:0]  cfg_data
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SW    = AW + 1;
  localparam int RCW   = RW + 1;
  localparam int CCW   = CW + 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;
  localparam logic [3:0] ST_SETUP = 4'd2;
  localparam logic [3:0] ST_FRD   = 4'd3;
  localparam logic [3:0] ST_FCHK  = 4'd4;
  localparam logic [3:0] ST_CRD   = 4'd5;
  localparam logic [3:0] ST_CWR   = 4'd6;
  localparam logic [3:0] ST_SZA   = 4'd7;
  localparam logic [3:0] ST_SZB   = 4'd8;
  localparam logic [3:0] ST_LINK  = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  // Join phases: left, upper, final test.
  localparam logic [1:0] PH_LEFT = 2'd0;
  localparam logic [1:0] PH_UP   = 2'd1;
  localparam logic [1:0] PH_FIN  = 2'd2;

  logic [3:0]       state;
  logic [1:0]       phase;
  logic             second;     // working on the second operand of a pair
  logic [DIM_W-1:0] grid_rows, grid_cols;
  logic [RW-1:0]    row_index, r_cur;
  logic [CW-1:0]    col_index, c_cur;
  logic [TILE_W-1:0] left_tile, tile;
  logic [AW-1:0]    cell_addr, start_a, start_b, walk, root_a, root_b;
  logic             last_cell;
  logic [SW-1:0]    size_a;

  // Clamp dimensions.
  logic [RCW-1:0] rows_eff;
  logic [CCW-1:0] cols_eff;
  always_comb begin
    if (grid_rows == '0) rows_eff = RCW'(1);
    else if (32'(grid_rows) > MAX_ROWS) rows_eff = RCW'(MAX_ROWS);
    else rows_eff = RCW'(grid_rows);
    if (grid_cols == '0) cols_eff = CCW'(1);
    else if (32'(grid_cols) > MAX_COLS) cols_eff = CCW'(MAX_COLS);
    else cols_eff = CCW'(grid_cols);
  end

  // RAM ports.
  logic          p_we, s_we, u_we;
  logic [AW-1:0] p_waddr, p_wdata, p_raddr, p_rdata, s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_rdata;
  logic [TILE_W-1:0] u_rdata;

  gtpc_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_parent (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr),
    .rdata(p_rdata));
  gtpc_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_size (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr),
    .rdata(s_rdata));
  gtpc_ram #(.WIDTH(TILE_W), .DEPTH(MAX_COLS)) u_upper (
    .clk, .we(u_we), .waddr(c_cur), .wdata(tile), .raddr(c_cur),
    .rdata(u_rdata));

  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  logic [AW-1:0] root_cur;
  assign root_cur = second ? root_b : root_a;

  // Read/write address selection. The upper tile is replaced only once the
  // upper join has been decided, so the read port still shows the old row.
  always_comb begin
    p_we = 1'b0; p_waddr = cell_addr; p_wdata = cell_addr;
    s_we = 1'b0; s_waddr = cell_addr; s_wdata = SW'(1);
    u_we = 1'b0;
    p_raddr = walk; s_raddr = root_a;
    unique case (state)
      ST_INIT: begin
        p_we = 1'b1; s_we = 1'b1;
      end
      ST_SETUP: begin
        if (phase == PH_FIN) u_we = 1'b1;
      end
      ST_CWR: begin
        p_we = 1'b1; p_waddr = walk; p_wdata = root_cur;
      end
      ST_SZB: s_raddr = root_b;
      ST_LINK: begin
        if (root_a != root_b) begin
          p_we = 1'b1; s_we = 1'b1;
          if (s_rdata > size_a) begin
            p_waddr = root_a; p_wdata = root_b; s_waddr = root_b;
          end else begin
            p_waddr = root_b; p_wdata = root_a; s_waddr = root_a;
          end
          s_wdata = s_rdata + size_a;
        end
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; grid_rows <= DIM_W'(1); grid_cols <= DIM_W'(1);
      row_index <= '0; col_index <= '0; left_tile <= '0;
      out_valid <= 1'b0; phase <= PH_LEFT; second <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_ROWS) grid_rows <= cfg_data;
            else grid_cols <= cfg_data;
            row_index <= '0; col_index <= '0; left_tile <= '0;
          end else if (in_valid) begin
            tile <= tile_code;
            if (RCW'(row_index) >= rows_eff || CCW'(col_index) >= cols_eff) begin
              r_cur <= '0; c_cur <= '0; cell_addr <= '0;
            end else begin
              r_cur <= row_index; c_cur <= col_index;
              cell_addr <= AW'(row_index * MAX_COLS) + AW'(col_index);
            end
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          last_cell <= (CCW'(c_cur) + CCW'(1) >= cols_eff) &&
                       (RCW'(r_cur) + RCW'(1) >= rows_eff);
          phase <= PH_LEFT;
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          second <= 1'b0;
          unique case (phase)
            PH_LEFT: begin
              if (c_cur != '0 && opens_right(left_tile) && opens_left(tile)) begin
                start_a <= cell_addr; start_b <= cell_addr - AW'(1);
                walk <= cell_addr; state <= ST_FRD;
              end else phase <= PH_UP;
            end
            PH_UP: begin
              if (r_cur != '0 && opens_down(u_rdata) && opens_up(tile)) begin
                start_a <= cell_addr; start_b <= cell_addr - AW'(MAX_COLS);
                walk <= cell_addr; state <= ST_FRD;
              end else phase <= PH_FIN;
            end
            PH_FIN: begin
              if (CCW'(c_cur) + CCW'(1) < cols_eff) begin
                left_tile <= tile;
                row_index <= r_cur; col_index <= c_cur + CW'(1);
                state <= ST_IDLE;
              end else begin
                left_tile <= '0; col_index <= '0;
                if (!last_cell) begin
                  row_index <= r_cur + RW'(1); state <= ST_IDLE;
                end else begin
                  row_index <= '0; start_a <= '0; start_b <= cell_addr;
                  walk <= '0; state <= ST_FRD;
                end
              end
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_FRD: state <= ST_FCHK;
        ST_FCHK: begin
          // Walk to the root, then compress from the start.
          if (p_rdata == walk) begin
            if (second) root_b <= walk; else root_a <= walk;
            walk <= second ? start_b : start_a;
            state <= ST_CRD;
          end else begin
            walk <= p_rdata; state <= ST_FRD;
          end
        end
        ST_CRD: begin
          if (walk == root_cur) begin
            if (!second) begin
              second <= 1'b1; walk <= start_b; state <= ST_FRD;
            end else if (phase == PH_FIN) begin
              path_exists <= (root_a == root_b); out_valid <= 1'b1;
              state <= ST_OUT;
            end else state <= ST_SZA;
          end else state <= ST_CWR;
        end
        ST_CWR: begin
          walk <= p_rdata; state <= ST_CRD;
        end
        ST_SZA: state <= ST_SZB;
        ST_SZB: begin
          size_a <= s_rdata; state <= ST_LINK;
        end
        ST_LINK: begin
          phase <= phase + 2'd1; state <= ST_SETUP;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0; state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The result beat is only offered while the sequencer waits in its output state.
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_OUT)) else $error("result beat outside output state");
  // No input beat is taken while a result is pending.
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input accepted while result pending");
  // A beat accepted moves the sequencer out of idle.
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_INIT)) else $error("cell not started");

endmodule
